// ----- src/layered_model_depth_lookup_defines.svh -----
// Assertion macros for the layered model depth lookup.
// Standalone header; included by the modules that carry checks.
`ifndef LAYERED_MODEL_DEPTH_LOOKUP_DEFINES_SVH
`define LAYERED_MODEL_DEPTH_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
// check with reset masking
`define LMDL_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lmdl check failed");
// check that also holds during reset
`define LMDL_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lmdl check failed");
`else
`define LMDL_ASSERT_RST(lbl, clk, rst, prop)
`define LMDL_ASSERT_ALL(lbl, clk, prop)
`endif

`endif

// ----- src/lmdl_pkg.sv -----
// Shared constants, codes and types for the layered model depth lookup.
// No dependencies.
package lmdl_pkg;

   localparam int MAX_LAYERS  = 16;
   localparam int IDX_W       = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int CNT_W       = $clog2(MAX_LAYERS + 1);
   localparam int DEPTH_W     = 32;
   localparam int VEL_W       = 24;
   localparam int SLOT_W      = 4;
   localparam int LNUM_W      = 4;
   localparam int LCNT_W      = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX       = 3'd4;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]          last_idx;
      logic signed [DEPTH_W-1:0] x_min;
      logic signed [DEPTH_W-1:0] x_max;
      logic signed [DEPTH_W-1:0] y_min;
      logic signed [DEPTH_W-1:0] y_max;
   } cfg_type;

   // load: d0 = top, d1 = bottom; query: d0 = depth, d1 = other depth
   typedef struct packed {
      logic                      is_query;
      logic [SLOT_W-1:0]         slot;
      logic signed [DEPTH_W-1:0] d0;
      logic signed [DEPTH_W-1:0] d1;
      logic [VEL_W-1:0]          vel;
      logic                      wok;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ----- src/lmdl_csr.sv -----
// Configuration registers and derived layer limits.
// Depends on lmdl_pkg.
module lmdl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lmdl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lmdl_pkg::DEPTH_W-1:0]     csr_wdata,
   output lmdl_pkg::cfg_type                cfg
);
   import lmdl_pkg::*;

   logic [LCNT_W-1:0]         layer_count_ff, layer_count_in;
   logic signed [DEPTH_W-1:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic signed [DEPTH_W-1:0] y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic                      wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      layer_count_in = layer_count_ff;
      x_min_in       = x_min_ff;
      x_max_in       = x_max_ff;
      y_min_in       = y_min_ff;
      y_max_in       = y_max_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_LAYER_COUNT: layer_count_in = csr_wdata[LCNT_W-1:0];
            CSR_X_MIN:       x_min_in       = $signed(csr_wdata);
            CSR_X_MAX:       x_max_in       = $signed(csr_wdata);
            CSR_Y_MIN:       y_min_in       = $signed(csr_wdata);
            CSR_Y_MAX:       y_max_in       = $signed(csr_wdata);
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= LCNT_W'(1);
         x_min_ff       <= '0;
         x_max_ff       <= '0;
         y_min_ff       <= '0;
         y_max_ff       <= '0;
      end else begin
         layer_count_ff <= layer_count_in;
         x_min_ff       <= x_min_in;
         x_max_ff       <= x_max_in;
         y_min_ff       <= y_min_in;
         y_max_ff       <= y_max_in;
      end
   end

   // zero acts as one layer, oversize clamps to the table size
   always_comb begin
      int n;
      n = int'(layer_count_ff);
      if (n < 1)          n = 1;
      if (n > MAX_LAYERS) n = MAX_LAYERS;
      cfg.last_idx = IDX_W'(n - 1);
      cfg.x_min    = x_min_ff;
      cfg.x_max    = x_max_ff;
      cfg.y_min    = y_min_ff;
      cfg.y_max    = y_max_ff;
   end

endmodule

// ----- src/lmdl_front.sv -----
// Front end: takes transactions, classifies load/query, does the window check
// and queues them for the back end. Depends on lmdl_pkg.
module lmdl_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [lmdl_pkg::SLOT_W-1:0]        req_layer_slot,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_load_top,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_load_bottom,
   input  logic [lmdl_pkg::VEL_W-1:0]         req_load_velocity,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_x,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_y,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_depth,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_other_depth,
   input  lmdl_pkg::cfg_type                  cfg,
   output lmdl_pkg::head_type                 head,
   input  logic                               pop
);
   import lmdl_pkg::*;

   item_type          q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   item_type          new_item;

   assign busy = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push = start & ~busy;

   always_comb begin
      new_item.is_query = (req_type == REQ_QUERY);
      new_item.slot     = req_layer_slot;
      new_item.d0       = new_item.is_query ? req_query_depth : req_load_top;
      new_item.d1       = new_item.is_query ? req_other_depth : req_load_bottom;
      new_item.vel      = req_load_velocity;
      new_item.wok      = ($signed(cfg.x_min) <= req_query_x) &&
                          (req_query_x <= $signed(cfg.x_max)) &&
                          ($signed(cfg.y_min) <= req_query_y) &&
                          (req_query_y <= $signed(cfg.y_max));
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

endmodule

// ----- src/lmdl_back.sv -----
// Back end: layer table, two scan passes over the used layers and the
// result registers. Depends on lmdl_pkg and the assertion macro header.
`include "layered_model_depth_lookup_defines.svh"
module lmdl_back (
   input  logic                                clock,
   input  logic                                reset,
   input  lmdl_pkg::cfg_type                   cfg,
   input  lmdl_pkg::head_type                  head,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic                                rsp_in_extent,
   output logic                                rsp_depth_ok,
   output logic                                rsp_other_ok,
   output logic [lmdl_pkg::LNUM_W-1:0]         rsp_layer_number,
   output logic [lmdl_pkg::VEL_W-1:0]          rsp_point_velocity,
   output logic [lmdl_pkg::VEL_W-1:0]          rsp_velocity_above,
   output logic [lmdl_pkg::VEL_W-1:0]          rsp_velocity_below,
   output logic [lmdl_pkg::LNUM_W-1:0]         rsp_interfaces_crossed,
   output logic [lmdl_pkg::VEL_W-1:0]          rsp_span_max_velocity
);
   import lmdl_pkg::*;

   localparam int             ST_W     = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_SCAN1 = 3'd1;
   localparam logic [ST_W-1:0] ST_CALC  = 3'd2;
   localparam logic [ST_W-1:0] ST_SCAN2 = 3'd3;
   localparam logic [ST_W-1:0] ST_FINAL = 3'd4;

   // layer table
   logic signed [DEPTH_W-1:0] top_mem    [MAX_LAYERS];
   logic signed [DEPTH_W-1:0] bottom_mem [MAX_LAYERS];
   logic [VEL_W-1:0]          vel_mem    [MAX_LAYERS];

   logic [ST_W-1:0]           state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          cnt_q_ff, cnt_q_in, cnt_o_ff, cnt_o_in;
   logic signed [DEPTH_W-1:0] top0_ff, top0_in, botl_ff, botl_in;
   logic                      dok_ff, dok_in, ook_ff, ook_in;
   logic [IDX_W-1:0]          qi_ff, qi_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [DEPTH_W-1:0] top_q_ff, top_q_in, bot_q_ff, bot_q_in;
   logic [VEL_W-1:0]          vel_q_ff, vel_q_in, vel_p_ff, vel_p_in;
   logic [VEL_W-1:0]          vel_n_ff, vel_n_in, vmax_ff, vmax_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      in_extent_ff, in_extent_in, depth_ok_ff, depth_ok_in;
   logic                      other_ok_ff, other_ok_in;
   logic [LNUM_W-1:0]         lnum_ff, lnum_in, cross_ff, cross_in;
   logic [VEL_W-1:0]          vpoint_ff, vpoint_in, vabove_ff, vabove_in;
   logic [VEL_W-1:0]          vbelow_ff, vbelow_in, vspan_ff, vspan_in;

   logic signed [DEPTH_W-1:0] rd_top, rd_bot, z, z2;
   logic [VEL_W-1:0]          rd_vel;
   logic                      wr_en, is_last;

   assign rd_top  = top_mem[idx_ff];
   assign rd_bot  = bottom_mem[idx_ff];
   assign rd_vel  = vel_mem[idx_ff];
   assign z       = head.item.d0;
   assign z2      = head.item.d1;
   assign is_last = (idx_ff == cfg.last_idx);

   assign wr_en = (state_ff == ST_IDLE) && head.valid && !head.item.is_query &&
                  (int'(head.item.slot) < MAX_LAYERS);
   assign pop   = ((state_ff == ST_IDLE) && head.valid && !head.item.is_query) ||
                  (state_ff == ST_FINAL);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         top_mem[IDX_W'(head.item.slot)]    <= head.item.d0;
         bottom_mem[IDX_W'(head.item.slot)] <= head.item.d1;
         vel_mem[IDX_W'(head.item.slot)]    <= head.item.vel;
      end
   end

   always_comb begin
      logic [IDX_W-1:0]          oi;
      logic [IDX_W:0]            idx_x, qi_x;
      logic signed [DEPTH_W+1:0] twice, sum;
      logic                      below_mid, inm;

      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_q_in     = cnt_q_ff;
      cnt_o_in     = cnt_o_ff;
      top0_in      = top0_ff;
      botl_in      = botl_ff;
      dok_in       = dok_ff;
      ook_in       = ook_ff;
      qi_in        = qi_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      top_q_in     = top_q_ff;
      bot_q_in     = bot_q_ff;
      vel_q_in     = vel_q_ff;
      vel_p_in     = vel_p_ff;
      vel_n_in     = vel_n_ff;
      vmax_in      = vmax_ff;
      rsp_valid_in = 1'b0;
      in_extent_in = in_extent_ff;
      depth_ok_in  = depth_ok_ff;
      other_ok_in  = other_ok_ff;
      lnum_in      = lnum_ff;
      cross_in     = cross_ff;
      vpoint_in    = vpoint_ff;
      vabove_in    = vabove_ff;
      vbelow_in    = vbelow_ff;
      vspan_in     = vspan_ff;

      oi        = '0;
      idx_x     = {1'b0, idx_ff};
      qi_x      = {1'b0, qi_ff};
      twice     = {z[DEPTH_W-1], z, 1'b0};
      sum       = {{2{top_q_ff[DEPTH_W-1]}}, top_q_ff} +
                  {{2{bot_q_ff[DEPTH_W-1]}}, bot_q_ff};
      below_mid = (twice < sum);
      inm       = dok_ff && head.item.wok;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.item.is_query) begin
               state_in = ST_SCAN1;
               idx_in   = '0;
               cnt_q_in = '0;
               cnt_o_in = '0;
            end
         end
         // pass one: extent of the model and bottoms at or above each depth
         ST_SCAN1: begin
            if (idx_ff == '0) top0_in = rd_top;
            if (is_last)      botl_in = rd_bot;
            cnt_q_in = cnt_q_ff + CNT_W'(rd_bot <= z);
            cnt_o_in = cnt_o_ff + CNT_W'(rd_bot <= z2);
            if (is_last) begin
               state_in = ST_CALC;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_CALC: begin
            dok_in = (z >= top0_ff) && (z <= botl_ff);
            ook_in = (z2 >= top0_ff) && (z2 <= botl_ff);
            qi_in  = (cnt_q_ff > CNT_W'(cfg.last_idx)) ? cfg.last_idx :
                     cnt_q_ff[IDX_W-1:0];
            oi     = (cnt_o_ff > CNT_W'(cfg.last_idx)) ? cfg.last_idx :
                     cnt_o_ff[IDX_W-1:0];
            lo_in  = (qi_in < oi) ? qi_in : oi;
            hi_in  = (qi_in < oi) ? oi : qi_in;
            vmax_in  = '0;
            vel_p_in = '0;
            vel_n_in = '0;
            idx_in   = '0;
            state_in = ST_SCAN2;
         end
         // pass two: pick up the layer and its neighbors, max over the span
         ST_SCAN2: begin
            if (idx_ff == qi_ff) begin
               top_q_in = rd_top;
               bot_q_in = rd_bot;
               vel_q_in = rd_vel;
            end
            if (idx_x + {{IDX_W{1'b0}}, 1'b1} == qi_x) vel_p_in = rd_vel;
            if (idx_x == qi_x + {{IDX_W{1'b0}}, 1'b1}) vel_n_in = rd_vel;
            if ((idx_ff >= lo_ff) && (idx_ff <= hi_ff) && (rd_vel > vmax_ff)) begin
               vmax_in = rd_vel;
            end
            if (is_last) begin
               state_in = ST_FINAL;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FINAL: begin
            rsp_valid_in = 1'b1;
            in_extent_in = inm;
            depth_ok_in  = dok_ff;
            other_ok_in  = ook_ff;
            lnum_in      = dok_ff ? LNUM_W'(qi_ff) : '0;
            vpoint_in    = inm ? vel_q_ff : '0;
            if (!dok_ff) begin
               vabove_in = '0;
               vbelow_in = '0;
            end else if (below_mid) begin
               vabove_in = (qi_ff == '0) ? '0 : vel_p_ff;
               vbelow_in = vel_q_ff;
            end else begin
               vabove_in = vel_q_ff;
               vbelow_in = (qi_ff == cfg.last_idx) ? '0 : vel_n_ff;
            end
            cross_in = (dok_ff && ook_ff) ? LNUM_W'(hi_ff - lo_ff) : '0;
            vspan_in = (dok_ff && ook_ff) ? vmax_ff : '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_q_ff     <= cnt_q_in;
      cnt_o_ff     <= cnt_o_in;
      top0_ff      <= top0_in;
      botl_ff      <= botl_in;
      dok_ff       <= dok_in;
      ook_ff       <= ook_in;
      qi_ff        <= qi_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      top_q_ff     <= top_q_in;
      bot_q_ff     <= bot_q_in;
      vel_q_ff     <= vel_q_in;
      vel_p_ff     <= vel_p_in;
      vel_n_ff     <= vel_n_in;
      vmax_ff      <= vmax_in;
      in_extent_ff <= in_extent_in;
      depth_ok_ff  <= depth_ok_in;
      other_ok_ff  <= other_ok_in;
      lnum_ff      <= lnum_in;
      cross_ff     <= cross_in;
      vpoint_ff    <= vpoint_in;
      vabove_ff    <= vabove_in;
      vbelow_ff    <= vbelow_in;
      vspan_ff     <= vspan_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_in_extent          = in_extent_ff;
   assign rsp_depth_ok           = depth_ok_ff;
   assign rsp_other_ok           = other_ok_ff;
   assign rsp_layer_number       = lnum_ff;
   assign rsp_point_velocity     = vpoint_ff;
   assign rsp_velocity_above     = vabove_ff;
   assign rsp_velocity_below     = vbelow_ff;
   assign rsp_interfaces_crossed = cross_ff;
   assign rsp_span_max_velocity  = vspan_ff;

   // idx is zero outside the scans; the host must change config only while idle (not enforced)
   `LMDL_ASSERT_RST(a_rsp_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff)
   `LMDL_ASSERT_RST(a_rsp_after_final, clock, reset, rsp_valid_ff |-> $past(state_ff == ST_FINAL))
   `LMDL_ASSERT_RST(a_pop_has_head, clock, reset, pop |-> head.valid)
   `LMDL_ASSERT_RST(a_idx_in_range, clock, reset, idx_ff <= cfg.last_idx)
   `LMDL_ASSERT_ALL(a_no_rsp_in_reset, clock, $past(reset) |-> !rsp_valid_ff)

endmodule

// ----- src/layered_model_depth_lookup.sv -----
// A query stays at the head of the front queue while the back end makes two
// passes over the N layers in use (1..16), one table entry a cycle, with a
// calc state between them and a final state; a load is retired from idle.
// The two-entry front queue raises busy when full; results are never held off.
// Synchronous active-high reset clears control state and the configuration
// (one layer, zero window); the layer table is undefined until loaded.
//
// Top level of the layered model depth lookup. Depends on lmdl_pkg,
// lmdl_csr, lmdl_front and lmdl_back.
module layered_model_depth_lookup (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [lmdl_pkg::SLOT_W-1:0]        req_layer_slot,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_load_top,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_load_bottom,
   input  logic [lmdl_pkg::VEL_W-1:0]         req_load_velocity,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_x,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_y,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_query_depth,
   input  logic signed [lmdl_pkg::DEPTH_W-1:0] req_other_depth,
   // result channel, one-cycle strobe, cannot be stalled
   output logic                               rsp_valid,
   output logic                               rsp_in_extent,
   output logic                               rsp_depth_ok,
   output logic                               rsp_other_ok,
   output logic [lmdl_pkg::LNUM_W-1:0]        rsp_layer_number,
   output logic [lmdl_pkg::VEL_W-1:0]         rsp_point_velocity,
   output logic [lmdl_pkg::VEL_W-1:0]         rsp_velocity_above,
   output logic [lmdl_pkg::VEL_W-1:0]         rsp_velocity_below,
   output logic [lmdl_pkg::LNUM_W-1:0]        rsp_interfaces_crossed,
   output logic [lmdl_pkg::VEL_W-1:0]         rsp_span_max_velocity,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lmdl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmdl_pkg::DEPTH_W-1:0]       csr_wdata
);
   import lmdl_pkg::*;

   cfg_type  cfg;    // live configuration, clamped layer limit
   head_type head;   // oldest queued transaction
   logic     pop;    // back end retires the head

   // Configuration: layer count and horizontal window. The host must write only
   // while idle, so both ends see a stable copy; the block does not enforce it.
   lmdl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Front: accept, tag load vs. query, check x/y against the window and
   // queue the transaction. Loads and queries share the queue so a load
   // never overtakes an earlier query.
   lmdl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_layer_slot    (req_layer_slot),
      .req_load_top      (req_load_top),
      .req_load_bottom   (req_load_bottom),
      .req_load_velocity (req_load_velocity),
      .req_query_x       (req_query_x),
      .req_query_y       (req_query_y),
      .req_query_depth   (req_query_depth),
      .req_other_depth   (req_other_depth),
      .cfg               (cfg),
      .head              (head),
      .pop               (pop)
   );

   // Back: layer table writes, and for a query a first pass that finds the
   // model extent and layer indexes, a second pass that fetches the layer,
   // its neighbors and the span maximum, then the registered result.
   lmdl_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .head                   (head),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_in_extent          (rsp_in_extent),
      .rsp_depth_ok           (rsp_depth_ok),
      .rsp_other_ok           (rsp_other_ok),
      .rsp_layer_number       (rsp_layer_number),
      .rsp_point_velocity     (rsp_point_velocity),
      .rsp_velocity_above     (rsp_velocity_above),
      .rsp_velocity_below     (rsp_velocity_below),
      .rsp_interfaces_crossed (rsp_interfaces_crossed),
      .rsp_span_max_velocity  (rsp_span_max_velocity)
   );

endmodule
